### sv/bitfield_record_packer_defines.svh
// ---------------------------------------------------------------------------
// Bitfield record packer assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef BITFIELD_RECORD_PACKER_DEFINES_SVH
`define BITFIELD_RECORD_PACKER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BFP_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bitfield record packer: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define BFP_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bitfield record packer: next-cycle check failed");

`endif

### sv/bfp_pkg.sv
// ---------------------------------------------------------------------------
// Bitfield record packer package
// Beat types, the job passed from front to back, and sizing constants.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bfp_pkg;

  localparam int VALUE_W        = 32;
  localparam int WIDTH_W        = 6;
  localparam int MAX_FIELD_BITS = 32;
  localparam int BYTE_W         = 8;
  localparam int PEND_W         = BYTE_W - 1;
  localparam int PCNT_W         = 3;
  localparam int TOTAL_W        = 6;
  localparam int ACC_W          = VALUE_W + PEND_W;
  localparam int NBYTES_W       = 3;
  localparam int JOB_DEPTH      = 4;
  localparam int JOB_PTR_W      = $clog2(JOB_DEPTH);
  localparam int JOB_CNT_W      = JOB_PTR_W + 1;

  typedef struct packed {
    logic [VALUE_W-1:0] field_value;
    logic [WIDTH_W-1:0] field_width;
    logic               last_field;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              last_byte;
  } out_item_t;

  typedef struct packed {
    logic [ACC_W-1:0]    acc;
    logic [NBYTES_W-1:0] nbytes;
    logic                last;
  } job_t;

endpackage

`default_nettype wire

### sv/bfp_front.sv
// ---------------------------------------------------------------------------
// Bitfield record packer front end
// Masks each field, merges it with the held partial byte, queues any bytes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bfp_front import bfp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  in_item_t          in_item,
  input  logic              job_full,
  output logic              job_push,
  output job_t              job,
  output logic [PCNT_W-1:0] pend_count
);

  logic [PEND_W-1:0]  pend_bits_r, pend_bits_nxt;
  logic [PCNT_W-1:0]  pend_count_r, pend_count_nxt;
  logic               accept;
  logic [WIDTH_W-1:0] w_sat;
  logic [VALUE_W:0]   mask_wide;
  logic [VALUE_W-1:0] value_m;
  logic [ACC_W-1:0]   acc;
  logic [ACC_W-1:0]   shifted;
  logic [TOTAL_W-1:0] total;
  logic [2:0]         n_full;
  logic [2:0]         rem;
  logic               flush;

  assign full   = job_full;
  assign accept = push && !full;

  always_comb begin
    if (in_item.field_width > WIDTH_W'(MAX_FIELD_BITS)) begin
      w_sat = WIDTH_W'(MAX_FIELD_BITS);
    end else begin
      w_sat = in_item.field_width;
    end
    mask_wide = ((VALUE_W + 1)'(1) << w_sat) - (VALUE_W + 1)'(1);
    value_m   = in_item.field_value & mask_wide[VALUE_W-1:0];
    acc       = {{VALUE_W{1'b0}}, pend_bits_r} | ({{PEND_W{1'b0}}, value_m} << pend_count_r);
    total     = TOTAL_W'(pend_count_r) + TOTAL_W'(w_sat);
    n_full    = total[5:3];
    rem       = total[2:0];
    flush     = in_item.last_field && (rem != 3'd0);
    shifted   = acc >> {n_full, 3'b000};

    job.acc    = acc;
    job.nbytes = n_full + NBYTES_W'(flush);
    job.last   = in_item.last_field;
    job_push   = accept && (job.nbytes != '0);

    pend_bits_nxt  = pend_bits_r;
    pend_count_nxt = pend_count_r;
    if (accept) begin
      if (in_item.last_field) begin
        pend_bits_nxt  = '0;
        pend_count_nxt = '0;
      end else begin
        pend_bits_nxt  = shifted[PEND_W-1:0];
        pend_count_nxt = rem;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_bits_r  <= '0;
      pend_count_r <= '0;
    end else begin
      pend_bits_r  <= pend_bits_nxt;
      pend_count_r <= pend_count_nxt;
    end
  end

  assign pend_count = pend_count_r;

endmodule

`default_nettype wire

### sv/bfp_job_fifo.sv
// ---------------------------------------------------------------------------
// Bitfield record packer job queue
// Short first-in first-out queue that decouples the front from the back.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bfp_job_fifo import bfp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t din,
  output logic full,
  input  logic pop,
  output job_t dout,
  output logic empty
);

  job_t                 mem_r [JOB_DEPTH];
  logic [JOB_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [JOB_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [JOB_CNT_W-1:0] count_r, count_nxt;
  logic                 do_push;
  logic                 do_pop;

  assign full    = (count_r == JOB_CNT_W'(JOB_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + JOB_PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + JOB_PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + JOB_CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - JOB_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

`default_nettype wire

### sv/bfp_back.sv
// ---------------------------------------------------------------------------
// Bitfield record packer back end
// Unloads queued jobs one byte per cycle into the output register unless held.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bfp_back import bfp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      job_empty,
  input  job_t      job,
  output logic      job_pop,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item
);

  logic [ACC_W-1:0]    acc_r, acc_nxt;
  logic [NBYTES_W-1:0] left_r, left_nxt;
  logic                last_r, last_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_item_r, out_item_nxt;
  logic                can_emit;
  logic                emit;
  logic                done_soon;

  always_comb begin
    can_emit  = !out_valid_r || pop;
    emit      = (left_r != '0) && can_emit;
    done_soon = (left_r == '0) || ((left_r == NBYTES_W'(1)) && emit);
    job_pop   = done_soon && !job_empty;

    acc_nxt  = acc_r;
    left_nxt = left_r;
    last_nxt = last_r;
    if (job_pop) begin
      acc_nxt  = job.acc;
      left_nxt = job.nbytes;
      last_nxt = job.last;
    end else if (emit) begin
      acc_nxt  = acc_r >> BYTE_W;
      left_nxt = left_r - NBYTES_W'(1);
    end

    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    if (emit) begin
      out_valid_nxt          = 1'b1;
      out_item_nxt.out_byte  = acc_r[BYTE_W-1:0];
      out_item_nxt.last_byte = last_r && (left_r == NBYTES_W'(1));
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      left_r      <= left_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r      <= acc_nxt;
    last_r     <= last_nxt;
    out_item_r <= out_item_nxt;
  end

  assign empty    = !out_valid_r;
  assign out_item = out_item_r;

endmodule

`default_nettype wire

### sv/bitfield_record_packer.sv
// A field's bytes pass the job queue and back end shift register into the output register.
// Throughput: one input beat per cycle while the four-entry job queue has room.
// The back end sends one byte per cycle while its output register is free or popped.
// Reset (synchronous, active low) empties the held partial byte, queue and output.
// ---------------------------------------------------------------------------
// Bitfield record packer
// Packs variable-width fields least significant bit first into a byte stream.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "bitfield_record_packer_defines.svh"

module bitfield_record_packer import bfp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  output logic      full,
  input  in_item_t  in_item,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item
);

  logic              job_full;
  logic              job_push;
  job_t              job;
  logic              job_pop;
  logic              job_empty;
  job_t              job_head;
  logic [PCNT_W-1:0] pend_count;

  bfp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (full),
    .in_item    (in_item),
    .job_full   (job_full),
    .job_push   (job_push),
    .job        (job),
    .pend_count (pend_count)
  );

  bfp_job_fifo u_job_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (job_push),
    .din   (job),
    .full  (job_full),
    .pop   (job_pop),
    .dout  (job_head),
    .empty (job_empty)
  );

  bfp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_empty (job_empty),
    .job       (job_head),
    .job_pop   (job_pop),
    .empty     (empty),
    .pop       (pop),
    .out_item  (out_item)
  );

  `BFP_ASSERT_NXT(a_last_clears_pending, push && !full && in_item.last_field, pend_count == '0)
  `BFP_ASSERT_IMP(a_job_push_has_room, job_push, !job_full)
  `BFP_ASSERT_IMP(a_job_pop_has_entry, job_pop, !job_empty)

endmodule

`default_nettype wire

### tb/tb.sv
// ---------------------------------------------------------------------------
// Bitfield record packer testbench
// Drives field beats through the push/full queue and checks every packed byte
// against a bit-level LSB-first model (typed directed rows: table bytes), under
// random idling on both sides and one long receiver hold-off that fills the block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import bfp_pkg::*;

  localparam int DIR_N       = 21;
  localparam int RAND_N      = 440;
  localparam int TOTAL_N     = DIR_N + RAND_N;
  localparam int CALM_TAIL   = 50;
  localparam int HOLD_AT     = DIR_N + 120;
  localparam int HOLD_CYCLES = 200;
  localparam int DRAIN       = 8;
  localparam int LIMIT       = 400000;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [WIDTH_W-1:0] width;
    logic               last;
    logic               typed;
    logic [2:0]         n;
    logic [39:0]        bytes;
  } dir_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      push = 1'b0;
  logic      pop = 1'b0;
  in_item_t  in_item = '0;
  logic      full;
  logic      empty;
  out_item_t out_item;

  logic [PEND_W-1:0] held_bits = '0;
  logic [PCNT_W-1:0] held_cnt = '0;
  out_item_t         step_bytes[$];
  out_item_t         packed_bytes_q[$];
  dir_row_t          dir_tab[DIR_N];

  int  accepted_n = 0;
  int  got_n = 0;
  int  rec_n = 0;
  int  err_n = 0;
  int  full_stalls = 0;
  int  cycles = 0;
  bit  sender_done = 1'b0;

  bitfield_record_packer u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_item  (in_item),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

  always #5 clk = ~clk;

  // Appends the field to the held partial byte and collects the bytes it completes.
  function automatic void pack_field(in_item_t b);
    logic [ACC_W-1:0] acc;
    logic [63:0]      val;
    int               w;
    int               total;
    step_bytes.delete();
    w = (b.field_width > MAX_FIELD_BITS) ? MAX_FIELD_BITS : int'(b.field_width);
    val = {32'd0, b.field_value} & ((64'd1 << w) - 64'd1);
    acc = ({{PEND_W{1'b0}}, val[VALUE_W-1:0]} << held_cnt) | {{VALUE_W{1'b0}}, held_bits};
    total = int'(held_cnt) + w;
    while (total >= BYTE_W) begin
      step_bytes.push_back('{out_byte: acc[BYTE_W-1:0], last_byte: 1'b0});
      acc = acc >> BYTE_W;
      total -= BYTE_W;
    end
    if (b.last_field) begin
      if (total > 0) begin
        step_bytes.push_back('{out_byte: acc[BYTE_W-1:0], last_byte: 1'b0});
        acc = '0;
        total = 0;
      end
      if (step_bytes.size() > 0) step_bytes[step_bytes.size()-1].last_byte = 1'b1;
    end
    held_bits = acc[PEND_W-1:0];
    held_cnt = total[PCNT_W-1:0];
  endfunction

  function automatic in_item_t random_field();
    in_item_t b;
    int       r;
    r = $urandom_range(0, 19);
    if (r == 0) b.field_width = '0;
    else if (r == 1) b.field_width = WIDTH_W'($urandom_range(33, 63));
    else b.field_width = WIDTH_W'($urandom_range(1, 32));
    r = $urandom_range(0, 9);
    if (r == 0) b.field_value = '1;
    else if (r == 1) b.field_value = '0;
    else b.field_value = $urandom;
    b.last_field = ($urandom_range(0, 3) == 0);
    return b;
  endfunction

  task automatic note_error(string msg);
    if (err_n < MAX_REPORTS) $display("%s", msg);
    err_n++;
  endtask

  initial begin : sender
    in_item_t beat;
    bit       calm;
    dir_tab[0]  = '{32'hFFFF_FFFF, 6'd32, 1'b1, 1'b1, 3'd4, 40'h00_FFFF_FFFF};
    dir_tab[1]  = '{32'h0000_0000, 6'd32, 1'b1, 1'b1, 3'd4, 40'h00_0000_0000};
    dir_tab[2]  = '{32'h0000_00A5, 6'd8,  1'b1, 1'b1, 3'd1, 40'h00_0000_00A5};
    dir_tab[3]  = '{32'hFFFF_FFFF, 6'd1,  1'b1, 1'b1, 3'd1, 40'h00_0000_0001};
    dir_tab[4]  = '{32'hDEAD_BEEF, 6'd0,  1'b1, 1'b1, 3'd0, 40'h00_0000_0000};
    dir_tab[5]  = '{32'h0000_0003, 6'd3,  1'b0, 1'b0, 3'd0, 40'h0};
    dir_tab[6]  = '{32'h0000_0000, 6'd0,  1'b1, 1'b1, 3'd1, 40'h00_0000_0003};
    dir_tab[7]  = '{32'hFFFF_FFFF, 6'd63, 1'b1, 1'b1, 3'd4, 40'h00_FFFF_FFFF};
    dir_tab[8]  = '{32'h1234_5678, 6'd33, 1'b0, 1'b1, 3'd4, 40'h00_1234_5678};
    dir_tab[9]  = '{32'h0000_007F, 6'd7,  1'b0, 1'b0, 3'd0, 40'h0};
    dir_tab[10] = '{32'hFFFF_FFFF, 6'd32, 1'b1, 1'b0, 3'd0, 40'h0};
    dir_tab[11] = '{32'h5555_5555, 6'd31, 1'b0, 1'b0, 3'd0, 40'h0};
    dir_tab[12] = '{32'h0000_0001, 6'd1,  1'b0, 1'b0, 3'd0, 40'h0};
    dir_tab[13] = '{32'hDEAD_BEEF, 6'd0,  1'b0, 1'b0, 3'd0, 40'h0};
    dir_tab[14] = '{32'h8000_0000, 6'd32, 1'b0, 1'b0, 3'd0, 40'h0};
    dir_tab[15] = '{32'h000A_BCDE, 6'd20, 1'b0, 1'b0, 3'd0, 40'h0};
    dir_tab[16] = '{32'h0000_0000, 6'd4,  1'b1, 1'b0, 3'd0, 40'h0};
    dir_tab[17] = '{32'h0000_0005, 6'd3,  1'b0, 1'b0, 3'd0, 40'h0};
    dir_tab[18] = '{32'h0000_001F, 6'd5,  1'b0, 1'b0, 3'd0, 40'h0};
    dir_tab[19] = '{32'h0000_0000, 6'd0,  1'b1, 1'b0, 3'd0, 40'h0};
    dir_tab[20] = '{32'hCAFE_F00D, 6'd13, 1'b1, 1'b0, 3'd0, 40'h0};
    wait (rst_n);
    for (int i = 0; i < TOTAL_N; i++) begin
      if (i < DIR_N) begin
        beat.field_value = dir_tab[i].value;
        beat.field_width = dir_tab[i].width;
        beat.last_field = dir_tab[i].last;
      end else begin
        beat = random_field();
      end
      calm = (i >= TOTAL_N - CALM_TAIL) || (i >= HOLD_AT - 5 && i < HOLD_AT + 40);
      if (!calm && $urandom_range(0, 5) == 0) begin
        push <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
      push <= 1'b1;
      in_item <= beat;
      do @(posedge clk); while (full);
      accepted_n++;
      pack_field(beat);
      if (i < DIR_N && dir_tab[i].typed) begin
        for (int k = 0; k < int'(dir_tab[i].n); k++) begin
          packed_bytes_q.push_back('{out_byte: dir_tab[i].bytes[8*k +: 8],
                                     last_byte: dir_tab[i].last && k == dir_tab[i].n - 1});
        end
      end else begin
        foreach (step_bytes[k]) packed_bytes_q.push_back(step_bytes[k]);
      end
    end
    push <= 1'b0;
    sender_done = 1'b1;
  end

  initial begin : receiver
    int        stall_left;
    bit        hold_done;
    out_item_t want;
    stall_left = 0;
    hold_done = 1'b0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (pop && !empty) begin
        got_n++;
        if (out_item.last_byte) rec_n++;
        if (packed_bytes_q.size() == 0) begin
          note_error($sformatf("unexpected beat %0d: byte %02h last %0b",
                               got_n, out_item.out_byte, out_item.last_byte));
        end else begin
          want = packed_bytes_q.pop_front();
          if (want.out_byte !== out_item.out_byte || want.last_byte !== out_item.last_byte) begin
            note_error($sformatf("beat %0d: expected byte %02h last %0b, got byte %02h last %0b",
                                 got_n, want.out_byte, want.last_byte,
                                 out_item.out_byte, out_item.last_byte));
          end
        end
      end
      if (!hold_done && accepted_n >= HOLD_AT) begin
        hold_done = 1'b1;
        stall_left = HOLD_CYCLES;
      end else if (stall_left == 0 && accepted_n < TOTAL_N - CALM_TAIL &&
                   $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 13);
      end
      if (stall_left > 0) begin
        pop <= 1'b0;
        stall_left--;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (rst_n && push && full) full_stalls++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles, %0d bytes still expected", cycles,
               packed_bytes_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin : run_ctl
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    wait (sender_done);
    while (packed_bytes_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    $display("Packed %0d field beats (%0d directed, %0d random) into %0d bytes over %0d records.",
             accepted_n, DIR_N, TOTAL_N - DIR_N, got_n, rec_n);
    $display("The input was held off by a full block for %0d cycles; %0d byte errors.",
             full_stalls, err_n);
    if (err_n == 0 && packed_bytes_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+sv
sv/bfp_pkg.sv
sv/bfp_front.sv
sv/bfp_job_fifo.sv
sv/bfp_back.sv
sv/bitfield_record_packer.sv
tb/tb.sv
